// File: hw/rtl/jsp_pkg.sv
// ----------------------------------------------------------------------------
// JSON object stream parser package
// Shared types, event and error codes, and the literal spelling tables.
// ----------------------------------------------------------------------------
package jsp_pkg;

	localparam int MAX_DEPTH = 16;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

	localparam logic [63:0] POS_LIMIT = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	typedef enum logic [12:0] {
		PH_OPEN     = 13'b0000000000001,
		PH_FIRSTKEY = 13'b0000000000010,
		PH_KEY      = 13'b0000000000100,
		PH_STR      = 13'b0000000001000,
		PH_ESC      = 13'b0000000010000,
		PH_HEX      = 13'b0000000100000,
		PH_COLON    = 13'b0000001000000,
		PH_VALUE    = 13'b0000010000000,
		PH_ARRFIRST = 13'b0000100000000,
		PH_LIT      = 13'b0001000000000,
		PH_NUM      = 13'b0010000000000,
		PH_AFTER    = 13'b0100000000000,
		PH_TRAIL    = 13'b1000000000000
	} phase_t;

	typedef enum logic [3:0] {
		EV_KEYBYTE  = 4'd0,
		EV_KEYEND   = 4'd1,
		EV_STRBYTE  = 4'd2,
		EV_STREND   = 4'd3,
		EV_INT      = 4'd4,
		EV_TRUE     = 4'd5,
		EV_FALSE    = 4'd6,
		EV_NULL     = 4'd7,
		EV_ARROPEN  = 4'd8,
		EV_ARRCLOSE = 4'd9,
		EV_OBJEND   = 4'd10,
		EV_ERROR    = 4'd11,
		EV_OK       = 4'd12
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE       = 4'd0,
		ERR_EARLY_END  = 4'd1,
		ERR_NO_BRACE   = 4'd2,
		ERR_NO_QUOTE   = 4'd3,
		ERR_NO_COLON   = 4'd4,
		ERR_BAD_HEX    = 4'd5,
		ERR_ABOVE_L1   = 4'd6,
		ERR_BAD_ESC    = 4'd7,
		ERR_BAD_LIT    = 4'd8,
		ERR_NO_VALUE   = 4'd9,
		ERR_FRACTION   = 4'd10,
		ERR_BAD_NUMBER = 4'd11,
		ERR_NO_BRACKET = 4'd12,
		ERR_NO_BRACE_C = 4'd13,
		ERR_TRAILING   = 4'd14,
		ERR_TOO_DEEP   = 4'd15
	} err_t;

	typedef struct packed {
		phase_t               phase;
		logic [DEPTH_W-1:0]   depth;
		logic                 in_key;
		logic [15:0]          hex_acc;
		logic [2:0]           hex_cnt;
		logic [63:0]          mag;
		logic                 neg;
		logic                 has_digit;
		logic [1:0]           lit_which;
		logic [2:0]           lit_pos;
		logic                 failed;
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic [63:0] iv;
		logic [4:0]  nest;
		err_t        err;
	} event_t;

	typedef event_t [2:0] event_arr_t;

	localparam state_t STATE_RESET = '{
		phase: PH_OPEN, depth: '0, in_key: 1'b0, hex_acc: 16'd0, hex_cnt: 3'd0,
		mag: 64'd0, neg: 1'b0, has_digit: 1'b0, lit_which: 2'd0, lit_pos: 3'd0,
		failed: 1'b0
	};

	function automatic logic [2:0] lit_len(input logic [1:0] which);
		case (which)
			2'd0:    lit_len = 3'd4;
			2'd1:    lit_len = 3'd5;
			2'd2:    lit_len = 3'd4;
			default: lit_len = 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [2:0] pos);
		logic [39:0] txt;
		case (which)
			2'd0:    txt = {8'h00, "eurt"};
			2'd1:    txt = "eslaf";
			default: txt = {8'h00, "llun"};
		endcase
		lit_char = txt[{pos, 3'b000} +: 8];
	endfunction

endpackage

// File: hw/rtl/json_object_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// JSON object stream parser unit
// Parses one JSON object per text, one byte per clock when not stalled, into a
// word stream of events.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one text byte per word in s_tdata; s_tlast marks
// the final byte of a text. Each byte is decoded in the cycle it is taken,
// and its zero to three events are loaded into a small result buffer. The
// master channel sends those events one word each; m_tlast marks the last
// event caused by one input byte.
// The first event of an input word is offered in the cycle after the word is
// taken. A byte that yields at most one event can follow in the next cycle, so
// text goes in at one byte per clock while the receiver takes each event; a
// byte with two or three events holds the input while the buffer drains. The
// input is taken again in the cycle the last buffered event leaves.
// When the receiver stalls, the buffer holds its events and s_tready drops
// once the last buffered event is not being taken.
// Reset clears the buffer and the parser state to wait for an opening brace.
// ----------------------------------------------------------------------------
module json_object_stream_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // char_value, int_value, nest_level, error_code, zero pad
	output logic [3:0]  m_tuser,   // event_kind
	output logic        m_tlast    // final_of_run
);
	import jsp_pkg::*;

	state_t     state_q, state_nx;
	event_arr_t evs_nx, buf_q;
	logic [1:0] cnt_nx, cnt_q;
	logic       s_acc, m_acc;

	jsp_step u_step (
		.st          (state_q),
		.text_byte   (s_tdata),
		.end_of_text (s_tlast),
		.nx          (state_nx),
		.evs         (evs_nx),
		.ev_cnt      (cnt_nx)
	);

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tlast  = cnt_q == 2'd1;
	assign m_acc    = m_tvalid && m_tready;
	assign s_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tuser  = buf_q[0].kind;
	assign m_tdata  = {7'd0, buf_q[0].err, buf_q[0].nest, buf_q[0].iv, buf_q[0].ch};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			cnt_q   <= 2'd0;
		end else begin
			if (s_acc) begin
				state_q <= state_nx;
				cnt_q   <= cnt_nx;
			end else if (m_acc) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			buf_q <= evs_nx;
		end else if (m_acc) begin
			buf_q <= {buf_q[2], buf_q[2], buf_q[1]};
		end
	end

endmodule

// File: hw/rtl/jsp_step.sv
// ----------------------------------------------------------------------------
// JSON parser step logic
// Next state and up to three events for one input byte.
// ----------------------------------------------------------------------------
module jsp_step (
	input  jsp_pkg::state_t     st,
	input  logic [7:0]          text_byte,
	input  logic                end_of_text,
	output jsp_pkg::state_t     nx,
	output jsp_pkg::event_arr_t evs,
	output logic [1:0]          ev_cnt
);
	import jsp_pkg::*;

	function automatic logic [63:0] add_digit(input logic [63:0] m, input logic neg,
		input logic [3:0] d);
		logic [63:0] lim;
		logic [67:0] p;
		lim = neg ? NEG_LIMIT : POS_LIMIT;
		p = {1'b0, m, 3'b000} + {3'b000, m, 1'b0} + {64'd0, d};
		if (m > lim) begin
			add_digit = m;
		end else if (p > {4'd0, lim}) begin
			add_digit = '1;
		end else begin
			add_digit = p[63:0];
		end
	endfunction

	function automatic event_t mk(input kind_t k, input logic [7:0] c, input logic [63:0] v,
		input logic [DEPTH_W-1:0] dp, input err_t e);
		event_t r;
		r.kind = k;
		r.ch   = c;
		r.iv   = v;
		r.nest = 5'(dp);
		r.err  = e;
		mk = r;
	endfunction

	logic       ws, is_digit, do_after, do_start, num_ok;
	logic [4:0] hexv;
	logic [15:0] hacc;
	logic [2:0] lpos;
	logic [3:0] dig;
	logic [63:0] nval;
	event_t     ev_none;

	always_comb begin
		nx       = st;
		evs      = '0;
		ev_cnt   = 2'd0;
		ev_none  = '0;
		do_after = 1'b0;
		do_start = 1'b0;
		hacc     = 16'd0;
		lpos     = 3'd0;
		nval     = 64'd0;
		num_ok   = 1'b0;
		ws       = text_byte == " " || text_byte == 8'h09 || text_byte == 8'h0a ||
			text_byte == 8'h0d;
		is_digit = text_byte >= "0" && text_byte <= "9";
		dig      = text_byte[3:0] - 4'd0;
		if (is_digit) begin
			hexv = {1'b0, text_byte[3:0]};
		end else if (text_byte >= "a" && text_byte <= "f") begin
			hexv = {1'b0, text_byte[3:0] + 4'd9};
		end else if (text_byte >= "A" && text_byte <= "F") begin
			hexv = {1'b0, text_byte[3:0] + 4'd9};
		end else begin
			hexv = 5'h10;
		end

		if (!st.failed) begin
			case (st.phase)
				PH_OPEN: begin
					if (!ws) begin
						if (text_byte == "{") begin
							nx.phase = PH_FIRSTKEY;
						end else begin
							evs[ev_cnt] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_NO_BRACE);
							ev_cnt = ev_cnt + 2'd1;
							nx.failed = 1'b1;
						end
					end
				end
				PH_FIRSTKEY, PH_KEY: begin
					if (!ws) begin
						if (text_byte == "}" && st.phase == PH_FIRSTKEY) begin
							evs[ev_cnt] = mk(EV_OBJEND, 8'd0, 64'd0, nx.depth, ERR_NONE);
							ev_cnt = ev_cnt + 2'd1;
							nx.phase = PH_TRAIL;
						end else if (text_byte == "\"") begin
							nx.in_key = 1'b1;
							nx.phase  = PH_STR;
						end else begin
							evs[ev_cnt] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_NO_QUOTE);
							ev_cnt = ev_cnt + 2'd1;
							nx.failed = 1'b1;
						end
					end
				end
				PH_STR: begin
					if (text_byte == "\"") begin
						if (st.in_key) begin
							evs[ev_cnt] = mk(EV_KEYEND, 8'd0, 64'd0, nx.depth, ERR_NONE);
							nx.phase = PH_COLON;
						end else begin
							evs[ev_cnt] = mk(EV_STREND, 8'd0, 64'd0, nx.depth, ERR_NONE);
							nx.phase = PH_AFTER;
						end
						ev_cnt = ev_cnt + 2'd1;
					end else if (text_byte == "\\") begin
						nx.phase = PH_ESC;
					end else begin
						evs[ev_cnt] = mk(st.in_key ? EV_KEYBYTE : EV_STRBYTE, text_byte,
							64'd0, nx.depth, ERR_NONE);
						ev_cnt = ev_cnt + 2'd1;
					end
				end
				PH_ESC: begin
					nx.phase = PH_STR;
					case (text_byte)
						"\"", "\\", "/": evs[0] = mk(st.in_key ? EV_KEYBYTE : EV_STRBYTE,
							text_byte, 64'd0, nx.depth, ERR_NONE);
						"b": evs[0] = mk(st.in_key ? EV_KEYBYTE : EV_STRBYTE, 8'd8, 64'd0,
							nx.depth, ERR_NONE);
						"f": evs[0] = mk(st.in_key ? EV_KEYBYTE : EV_STRBYTE, 8'd12, 64'd0,
							nx.depth, ERR_NONE);
						"n": evs[0] = mk(st.in_key ? EV_KEYBYTE : EV_STRBYTE, 8'd10, 64'd0,
							nx.depth, ERR_NONE);
						"r": evs[0] = mk(st.in_key ? EV_KEYBYTE : EV_STRBYTE, 8'd13, 64'd0,
							nx.depth, ERR_NONE);
						"t": evs[0] = mk(st.in_key ? EV_KEYBYTE : EV_STRBYTE, 8'd9, 64'd0,
							nx.depth, ERR_NONE);
						"u": begin
							nx.hex_acc = 16'd0;
							nx.hex_cnt = 3'd0;
							nx.phase   = PH_HEX;
						end
						default: begin
							evs[0] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_BAD_ESC);
							nx.phase  = PH_ESC;
							nx.failed = 1'b1;
						end
					endcase
					if (text_byte != "u") begin
						ev_cnt = 2'd1;
					end
				end
				PH_HEX: begin
					if (hexv[4]) begin
						evs[0] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_BAD_HEX);
						ev_cnt = 2'd1;
						nx.failed = 1'b1;
					end else begin
						hacc = {st.hex_acc[11:0], hexv[3:0]};
						nx.hex_acc = hacc;
						nx.hex_cnt = st.hex_cnt + 3'd1;
						if (st.hex_cnt >= 3'd3) begin
							ev_cnt = 2'd1;
							if (hacc > 16'h00ff) begin
								evs[0] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_ABOVE_L1);
								nx.failed = 1'b1;
							end else begin
								evs[0] = mk(st.in_key ? EV_KEYBYTE : EV_STRBYTE, hacc[7:0],
									64'd0, nx.depth, ERR_NONE);
								nx.phase = PH_STR;
							end
						end
					end
				end
				PH_COLON: begin
					if (!ws) begin
						if (text_byte == ":") begin
							nx.phase = PH_VALUE;
						end else begin
							evs[0] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_NO_COLON);
							ev_cnt = 2'd1;
							nx.failed = 1'b1;
						end
					end
				end
				PH_ARRFIRST: begin
					if (!ws) begin
						if (text_byte == "]") begin
							nx.depth = st.depth - DEPTH_W'(1);
							evs[0] = mk(EV_ARRCLOSE, 8'd0, 64'd0, nx.depth, ERR_NONE);
							ev_cnt = 2'd1;
							nx.phase = PH_AFTER;
						end else begin
							do_start = 1'b1;
						end
					end
				end
				PH_VALUE: begin
					do_start = !ws;
				end
				PH_LIT: begin
					if (st.lit_which > 2'd2 || st.lit_pos >= lit_len(st.lit_which) ||
						text_byte != lit_char(st.lit_which, st.lit_pos)) begin
						evs[0] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_BAD_LIT);
						ev_cnt = 2'd1;
						nx.failed = 1'b1;
					end else begin
						lpos = st.lit_pos + 3'd1;
						nx.lit_pos = lpos;
						if (lpos == lit_len(st.lit_which)) begin
							case (st.lit_which)
								2'd0:    evs[0] = mk(EV_TRUE, 8'd0, 64'd0, nx.depth, ERR_NONE);
								2'd1:    evs[0] = mk(EV_FALSE, 8'd0, 64'd0, nx.depth, ERR_NONE);
								default: evs[0] = mk(EV_NULL, 8'd0, 64'd0, nx.depth, ERR_NONE);
							endcase
							ev_cnt = 2'd1;
							nx.phase = PH_AFTER;
						end
					end
				end
				PH_NUM: begin
					num_ok = st.has_digit && st.mag <= (st.neg ? NEG_LIMIT : POS_LIMIT);
					if (is_digit) begin
						nx.mag = add_digit(st.mag, st.neg, dig);
						nx.has_digit = 1'b1;
					end else if (text_byte == "." || text_byte == "e" || text_byte == "E") begin
						evs[0] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_FRACTION);
						ev_cnt = 2'd1;
						nx.failed = 1'b1;
					end else if (!num_ok) begin
						evs[0] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_BAD_NUMBER);
						ev_cnt = 2'd1;
						nx.failed = 1'b1;
					end else begin
						nval = st.neg ? (64'd0 - st.mag) : st.mag;
						evs[0] = mk(EV_INT, 8'd0, nval, nx.depth, ERR_NONE);
						ev_cnt = 2'd1;
						nx.phase = PH_AFTER;
						do_after = 1'b1;
					end
				end
				PH_AFTER: begin
					do_after = 1'b1;
				end
				PH_TRAIL: begin
					if (!ws) begin
						evs[0] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_TRAILING);
						ev_cnt = 2'd1;
						nx.failed = 1'b1;
					end
				end
				default: begin
					evs[0] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_EARLY_END);
					ev_cnt = 2'd1;
					nx.failed = 1'b1;
				end
			endcase

			// The byte after a value: also reached by the byte that ends a number.
			if (do_after && !ws) begin
				if (st.depth == '0) begin
					if (text_byte == ",") begin
						nx.phase = PH_KEY;
					end else if (text_byte == "}") begin
						evs[ev_cnt] = mk(EV_OBJEND, 8'd0, 64'd0, nx.depth, ERR_NONE);
						ev_cnt = ev_cnt + 2'd1;
						nx.phase = PH_TRAIL;
					end else begin
						evs[ev_cnt] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_NO_BRACE_C);
						ev_cnt = ev_cnt + 2'd1;
						nx.failed = 1'b1;
					end
				end else begin
					if (text_byte == ",") begin
						nx.phase = PH_VALUE;
					end else if (text_byte == "]") begin
						nx.depth = st.depth - DEPTH_W'(1);
						evs[ev_cnt] = mk(EV_ARRCLOSE, 8'd0, 64'd0, nx.depth, ERR_NONE);
						ev_cnt = ev_cnt + 2'd1;
					end else begin
						evs[ev_cnt] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_NO_BRACKET);
						ev_cnt = ev_cnt + 2'd1;
						nx.failed = 1'b1;
					end
				end
			end

			if (do_start) begin
				if (text_byte == "\"") begin
					nx.in_key = 1'b0;
					nx.phase  = PH_STR;
				end else if (text_byte == "[") begin
					if (st.depth >= DEPTH_W'(MAX_DEPTH)) begin
						evs[0] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_TOO_DEEP);
						nx.failed = 1'b1;
					end else begin
						nx.depth = st.depth + DEPTH_W'(1);
						evs[0] = mk(EV_ARROPEN, 8'd0, 64'd0, nx.depth, ERR_NONE);
						nx.phase = PH_ARRFIRST;
					end
					ev_cnt = 2'd1;
				end else if (text_byte == "t" || text_byte == "f" || text_byte == "n") begin
					nx.lit_which = (text_byte == "t") ? 2'd0 : (text_byte == "f") ? 2'd1 : 2'd2;
					nx.lit_pos   = 3'd1;
					nx.phase     = PH_LIT;
				end else if (text_byte == "-" || is_digit) begin
					nx.neg       = text_byte == "-";
					nx.has_digit = is_digit;
					nx.mag       = is_digit ? add_digit(64'd0, 1'b0, dig) : 64'd0;
					nx.phase     = PH_NUM;
				end else begin
					evs[0] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_NO_VALUE);
					ev_cnt = 2'd1;
					nx.failed = 1'b1;
				end
			end
		end

		// End of text: close out what is pending, then return to the reset state.
		if (end_of_text) begin
			if (!nx.failed) begin
				if (nx.phase == PH_TRAIL) begin
					evs[ev_cnt] = mk(EV_OK, 8'd0, 64'd0, nx.depth, ERR_NONE);
				end else if (nx.phase == PH_LIT) begin
					evs[ev_cnt] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_BAD_LIT);
				end else if (nx.phase == PH_NUM) begin
					if (nx.has_digit && nx.mag <= (nx.neg ? NEG_LIMIT : POS_LIMIT)) begin
						evs[ev_cnt] = mk(EV_INT, 8'd0, nx.neg ? (64'd0 - nx.mag) : nx.mag,
							nx.depth, ERR_NONE);
						ev_cnt = ev_cnt + 2'd1;
						evs[ev_cnt] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_EARLY_END);
					end else begin
						evs[ev_cnt] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_BAD_NUMBER);
					end
				end else begin
					evs[ev_cnt] = mk(EV_ERROR, 8'd0, 64'd0, nx.depth, ERR_EARLY_END);
				end
				ev_cnt = ev_cnt + 2'd1;
			end
			nx = STATE_RESET;
		end
		if (ev_cnt == 2'd0) begin
			evs[0] = ev_none;
		end
	end

endmodule

// File: hw/rtl/jsp_checker.sv
// ----------------------------------------------------------------------------
// JSON parser port checker
// Checks on the top level's ports, bound to every instance of the unit.
// ----------------------------------------------------------------------------
module jsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);
	import jsp_pkg::*;

	// A stalled word stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	// New input is only taken when at most the last event of a byte is pending.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tlast)
		else $error("input taken with more than one event pending");

	// Error words carry a code, other words carry none.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == EV_ERROR) == (m_tdata[80:77] != 4'd0)))
		else $error("error code does not match event kind");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= EV_OK)
		else $error("event kind out of range");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[76:72] <= 5'(MAX_DEPTH))
		else $error("nesting level above limit");

endmodule

bind json_object_stream_parser_unit jsp_checker u_jsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
